// ===== src/spte_pkg.sv =====
// Shared types and constants for the stopping-power table block.
// Used by the controller, the datapath and the top level; no dependencies.
package spte_pkg;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NEED_ROWS = 2'd2;
    localparam logic [1:0] ST_CLAMPED   = 2'd3;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = 5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SRCH_RD,
        OP_SRCH_CMP,
        OP_FETCH_LO,
        OP_FETCH_HI,
        OP_SELECT,
        OP_LERP_MUL,
        OP_DIV_STEP,
        OP_LERP_END,
        OP_MUL_W,
        OP_SUM_W,
        OP_MUL_S,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ch;
    } t_dp_cmd;

    typedef struct packed {
        logic query;
        logic cnt_ok;
        logic lo_lt_hi;
        logic interp;
    } t_dp_stat;

endpackage

// ===== src/stopping_power_table_energy_loss_top.sv =====
// Append, clear, other commands and a query on fewer than two rows give their result in the
// cycle after the transfer. A query makes p search probes, p up to ceil(log2(rows+1)), each a
// read and a compare over one memory read port; then fetch and select, two multiply and
// bit-serial divide passes when it interpolates, and 4 weighting and finish steps.
// Throughput: one item at a time; the next transfer is taken after the result is taken.
// Reset clears the row count and control state; row memories are not cleared.
// Top level; depends on spte_pkg, spte_ctrl and spte_dp.
module stopping_power_table_energy_loss_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_command,
    input  logic [31:0]                       i_energy,
    input  logic [31:0]                       i_electronic_stopping,
    input  logic [31:0]                       i_nuclear_stopping,
    input  logic [15:0]                       i_electron_density_factor,
    input  logic [15:0]                       i_atom_density_factor,
    input  logic [31:0]                       i_step_length,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [31:0]                       o_new_energy,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  o_row_count,
    output logic [1:0]                        o_status
);
    import spte_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    spte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    spte_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cmd                     (w_cmd),
        .o_stat                    (w_stat),
        .i_command                 (i_command),
        .i_energy                  (i_energy),
        .i_electronic_stopping     (i_electronic_stopping),
        .i_nuclear_stopping        (i_nuclear_stopping),
        .i_electron_density_factor (i_electron_density_factor),
        .i_atom_density_factor     (i_atom_density_factor),
        .i_step_length             (i_step_length),
        .o_new_energy              (o_new_energy),
        .o_row_count               (o_row_count),
        .o_status                  (o_status)
    );

endmodule

// ===== src/spte_ctrl.sv =====
// Sequencing state machine for the stopping-power table block.
// Depends on spte_pkg; drives the datapath through command and status structs.
module spte_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  spte_pkg::t_dp_stat i_stat,
    output spte_pkg::t_dp_cmd  o_cmd
);
    import spte_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_CMP, S_FHI, S_SEL, S_MUL, S_DIV, S_END,
        S_MW, S_SW, S_MS, S_FIN, S_OUT
    } t_state;

    t_state              r_state;
    logic                r_valid;
    logic                r_ch;
    logic [DIV_CW-1:0]   r_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_ch      <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_stat.query && i_stat.cnt_ok) begin
                            r_state <= S_SRCH;
                        end else begin
                            r_state <= S_OUT;
                            r_valid <= 1'b1;
                        end
                    end
                end
                S_SRCH: begin
                    r_state <= i_stat.lo_lt_hi ? S_CMP : S_FHI;
                end
                S_CMP: r_state <= S_SRCH;
                S_FHI: r_state <= S_SEL;
                S_SEL: begin
                    r_ch    <= 1'b0;
                    r_state <= i_stat.interp ? S_MUL : S_MW;
                end
                S_MUL: begin
                    r_div_cnt <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_MW;
                    end
                end
                S_MW:  r_state <= S_SW;
                S_SW:  r_state <= S_MS;
                S_MS:  r_state <= S_FIN;
                S_FIN: begin
                    r_state <= S_OUT;
                    r_valid <= 1'b1;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.ch = r_ch;
        case (r_state)
            S_IDLE:  o_cmd.op = i_valid ? OP_ACCEPT : OP_NONE;
            S_SRCH:  o_cmd.op = i_stat.lo_lt_hi ? OP_SRCH_RD : OP_FETCH_LO;
            S_CMP:   o_cmd.op = OP_SRCH_CMP;
            S_FHI:   o_cmd.op = OP_FETCH_HI;
            S_SEL:   o_cmd.op = OP_SELECT;
            S_MUL:   o_cmd.op = OP_LERP_MUL;
            S_DIV:   o_cmd.op = OP_DIV_STEP;
            S_END:   o_cmd.op = OP_LERP_END;
            S_MW:    o_cmd.op = OP_MUL_W;
            S_SW:    o_cmd.op = OP_SUM_W;
            S_MS:    o_cmd.op = OP_MUL_S;
            S_FIN:   o_cmd.op = OP_FINISH;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== src/spte_dp.sv =====
// Datapath for the stopping-power table block: row memories, search pointers,
// shared multiplier stages and a bit-serial divider. Depends on spte_pkg.
module spte_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  spte_pkg::t_dp_cmd                  i_cmd,
    output spte_pkg::t_dp_stat                 o_stat,
    input  logic [1:0]                         i_command,
    input  logic [31:0]                        i_energy,
    input  logic [31:0]                        i_electronic_stopping,
    input  logic [31:0]                        i_nuclear_stopping,
    input  logic [15:0]                        i_electron_density_factor,
    input  logic [15:0]                        i_atom_density_factor,
    input  logic [31:0]                        i_step_length,
    output logic [31:0]                        o_new_energy,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]   o_row_count,
    output logic [1:0]                         o_status
);
    import spte_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [31:0] mem_e  [TABLE_DEPTH];
    logic [31:0] mem_se [TABLE_DEPTH];
    logic [31:0] mem_sn [TABLE_DEPTH];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_lo, r_hi, r_mid;
    logic [31:0]   r_rd_e, r_rd_se, r_rd_sn;
    logic [31:0]   r_e, r_step, r_res;
    logic [15:0]   r_fe, r_fa;
    logic [1:0]    r_status;
    logic [31:0]   r_x0, r_y0e, r_y0n, r_y1e, r_y1n, r_span;
    logic [31:0]   r_se, r_sn;
    logic [31:0]   r_rem, r_low;
    logic          r_neg;
    logic [47:0]   r_pe, r_pn;
    logic [40:0]   r_w;
    logic [63:0]   r_pl;
    logic [40:0]   r_ph;

    logic [CW-1:0] w_mid;
    logic [CW-1:0] w_addr_full;
    logic [AW-1:0] w_addr;
    logic          w_wr;
    logic          w_lo_zero, w_lo_end;
    logic [31:0]   w_y0, w_y1, w_mag;
    logic          w_neg;
    logic [63:0]   w_prod;
    logic [32:0]   w_t;
    logic          w_ge;
    logic [72:0]   w_tot;
    logic [47:0]   w_loss;

    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_lo_zero = (r_lo == '0);
    assign w_lo_end  = (r_lo == r_count);

    always_comb begin
        case (i_cmd.op)
            OP_SRCH_RD:  w_addr_full = w_mid;
            OP_FETCH_LO: w_addr_full = w_lo_zero ? '0 : CW'(r_lo - 1'b1);
            OP_FETCH_HI: w_addr_full = r_lo;
            default:     w_addr_full = '0;
        endcase
    end
    assign w_addr = w_addr_full[AW-1:0];

    assign w_wr = (i_cmd.op == OP_ACCEPT) && (i_command == CMD_APPEND)
                  && (r_count < CW'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem_e[r_count[AW-1:0]]  <= i_energy;
            mem_se[r_count[AW-1:0]] <= i_electronic_stopping;
            mem_sn[r_count[AW-1:0]] <= i_nuclear_stopping;
        end
        r_rd_e  <= mem_e[w_addr];
        r_rd_se <= mem_se[w_addr];
        r_rd_sn <= mem_sn[w_addr];
    end

    assign w_y0   = i_cmd.ch ? r_y0n : r_y0e;
    assign w_y1   = i_cmd.ch ? r_y1n : r_y1e;
    assign w_neg  = (w_y1 < w_y0);
    assign w_mag  = w_neg ? (w_y0 - w_y1) : (w_y1 - w_y0);
    assign w_prod = 64'(w_mag) * 64'(r_e - r_x0);
    assign w_t    = {r_rem, r_low[31]};
    assign w_ge   = (w_t >= {1'b0, r_span});
    assign w_tot  = {r_ph, 32'b0} + {9'b0, r_pl};
    assign w_loss = w_tot[63:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.op == OP_ACCEPT) begin
            if (w_wr) begin
                r_count <= r_count + 1'b1;
            end else if (i_command == CMD_CLEAR) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_e      <= i_energy;
                r_res    <= i_energy;
                r_fe     <= i_electron_density_factor;
                r_fa     <= i_atom_density_factor;
                r_step   <= i_step_length;
                r_lo     <= '0;
                r_hi     <= r_count;
                r_status <= ST_OK;
                if (i_command == CMD_APPEND && !w_wr) begin
                    r_status <= ST_FULL;
                end else if (i_command == CMD_QUERY && r_count < CW'(2)) begin
                    r_status <= ST_NEED_ROWS;
                end
            end
            OP_SRCH_RD: r_mid <= w_mid;
            OP_SRCH_CMP: begin
                if (r_rd_e <= r_e) begin
                    r_lo <= CW'(r_mid + 1'b1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            OP_FETCH_HI: begin
                r_x0  <= r_rd_e;
                r_y0e <= r_rd_se;
                r_y0n <= r_rd_sn;
            end
            OP_SELECT: begin
                r_y1e  <= r_rd_se;
                r_y1n  <= r_rd_sn;
                r_span <= r_rd_e - r_x0;
                r_se   <= r_y0e;
                r_sn   <= r_y0n;
                if (w_lo_zero) begin
                    r_status <= ST_CLAMPED;
                end else if (w_lo_end && r_x0 != r_e) begin
                    r_status <= ST_CLAMPED;
                end
            end
            OP_LERP_MUL: begin
                r_rem <= w_prod[63:32];
                r_low <= w_prod[31:0];
                r_neg <= w_neg;
            end
            OP_DIV_STEP: begin
                r_rem <= w_ge ? 32'(w_t - {1'b0, r_span}) : w_t[31:0];
                r_low <= {r_low[30:0], w_ge};
            end
            OP_LERP_END: begin
                if (i_cmd.ch) begin
                    r_sn <= r_neg ? (w_y0 - r_low) : (w_y0 + r_low);
                end else begin
                    r_se <= r_neg ? (w_y0 - r_low) : (w_y0 + r_low);
                end
            end
            OP_MUL_W: begin
                r_pe <= 48'(r_se) * 48'(r_fe);
                r_pn <= 48'(r_sn) * 48'(r_fa);
            end
            OP_SUM_W: r_w <= 41'((49'(r_pe) + 49'(r_pn)) >> 8);
            OP_MUL_S: begin
                r_pl <= 64'(r_w[31:0]) * 64'(r_step);
                r_ph <= 41'(r_w[40:32]) * 41'(r_step);
            end
            OP_FINISH: begin
                if (w_tot[72:64] != '0 || w_loss >= {16'b0, r_e}) begin
                    r_res <= '0;
                end else begin
                    r_res <= r_e - w_loss[31:0];
                end
            end
            default: ;
        endcase
    end

    assign o_stat.query    = (i_command == CMD_QUERY);
    assign o_stat.cnt_ok   = (r_count >= CW'(2));
    assign o_stat.lo_lt_hi = (r_lo < r_hi);
    assign o_stat.interp   = !w_lo_zero && !w_lo_end && (r_rd_e > r_x0)
                             && (r_e >= r_x0) && (r_e < r_rd_e);

    assign o_new_energy = r_res;
    assign o_row_count  = r_count;
    assign o_status     = r_status;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the stopping-power table block: drives random table
// loads, clears and energy-loss queries and compares every result with a local model.
// Depends on spte_pkg and stopping_power_table_energy_loss_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spte_pkg::*;

    localparam int DEPTH = 256;
    localparam longint LIMIT = 3000000;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct {
        logic [1:0]  command;
        logic [31:0] energy;
        logic [31:0] se;
        logic [31:0] sn;
        logic [15:0] fe;
        logic [15:0] fa;
        logic [31:0] step;
    } t_item;

    typedef struct {
        logic [31:0] new_energy;
        logic [8:0]  row_count;
        logic [1:0]  status;
    } t_loss;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_command = '0;
    logic [31:0] i_energy = '0;
    logic [31:0] i_electronic_stopping = '0;
    logic [31:0] i_nuclear_stopping = '0;
    logic [15:0] i_electron_density_factor = '0;
    logic [15:0] i_atom_density_factor = '0;
    logic [31:0] i_step_length = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [31:0] o_new_energy;
    logic [8:0] o_row_count;
    logic [1:0] o_status;

    stopping_power_table_energy_loss_top #(.TABLE_DEPTH(DEPTH)) dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_item pending_items[$];
    t_loss expected_losses[$];
    logic [31:0] tbl_energy[DEPTH];
    logic [31:0] tbl_elec[DEPTH];
    logic [31:0] tbl_nuc[DEPTH];
    int unsigned tbl_rows = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int unsigned hold_left = 0;
    int errors = 0;
    longint cycles = 0;

    function automatic logic [31:0] interp(logic [31:0] e, logic [31:0] x0, logic [31:0] x1,
                                           logic [31:0] y0, logic [31:0] y1);
        logic [63:0] d;
        logic [63:0] span;
        logic [63:0] mag;
        d = 64'(e - x0);
        span = 64'(x1 - x0);
        if (span == 0) return y0;
        if (y1 >= y0) begin
            mag = (64'(y1 - y0) * d) / span;
            return y0 + mag[31:0];
        end
        mag = (64'(y0 - y1) * d) / span;
        return y0 - mag[31:0];
    endfunction

    function automatic t_loss predict_loss(t_item it);
        t_loss r;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned n;
        logic [31:0] se;
        logic [31:0] sn;
        logic [31:0] x0;
        logic [31:0] x1;
        logic [127:0] w;
        logic [127:0] loss;
        r.new_energy = it.energy;
        r.status = ST_OK;
        if (it.command == CMD_APPEND) begin
            if (tbl_rows < DEPTH) begin
                tbl_energy[tbl_rows] = it.energy;
                tbl_elec[tbl_rows] = it.se;
                tbl_nuc[tbl_rows] = it.sn;
                tbl_rows++;
            end else begin
                r.status = ST_FULL;
            end
        end else if (it.command == CMD_CLEAR) begin
            tbl_rows = 0;
        end else if (it.command == CMD_QUERY) begin
            n = tbl_rows;
            if (n < 2) begin
                r.status = ST_NEED_ROWS;
            end else begin
                lo = 0;
                hi = n;
                while (lo < hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (tbl_energy[mid] <= it.energy) lo = mid + 1;
                    else hi = mid;
                end
                if (lo == 0) begin
                    se = tbl_elec[0];
                    sn = tbl_nuc[0];
                    r.status = ST_CLAMPED;
                end else if (lo >= n) begin
                    se = tbl_elec[n-1];
                    sn = tbl_nuc[n-1];
                    if (tbl_energy[n-1] != it.energy) r.status = ST_CLAMPED;
                end else begin
                    x0 = tbl_energy[lo-1];
                    x1 = tbl_energy[lo];
                    if (x1 <= x0 || it.energy < x0 || it.energy >= x1) begin
                        se = tbl_elec[lo-1];
                        sn = tbl_nuc[lo-1];
                    end else begin
                        se = interp(it.energy, x0, x1, tbl_elec[lo-1], tbl_elec[lo]);
                        sn = interp(it.energy, x0, x1, tbl_nuc[lo-1], tbl_nuc[lo]);
                    end
                end
                w = (128'(se) * it.fe + 128'(sn) * it.fa) >> 8;
                loss = w * it.step;
                if (loss[127:64] != 0) r.new_energy = '0;
                else begin
                    loss = loss >> 16;
                    r.new_energy = (loss >= it.energy) ? '0 : it.energy - loss[31:0];
                end
            end
        end
        r.row_count = 9'(tbl_rows);
        return r;
    endfunction

    function automatic t_item make_item(logic [1:0] c, logic [31:0] e);
        t_item it;
        it.command = c;
        it.energy = e;
        it.se = $urandom;
        it.sn = $urandom;
        it.fe = 16'($urandom);
        it.fa = 16'($urandom);
        it.step = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] rand_small();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0000_ffff);
            2: return $urandom_range(0, 32'h00ff_ffff);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic push(t_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_losses.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    task automatic add_table(int unsigned rows, bit sorted);
        t_item it;
        logic [31:0] e;
        e = $urandom_range(0, 32'h0010_0000);
        push(make_item(CMD_CLEAR, $urandom));
        for (int i = 0; i < rows; i++) begin
            it = make_item(CMD_APPEND, sorted ? e : $urandom);
            it.se = rand_small();
            it.sn = rand_small();
            push(it);
            e = e + $urandom_range(0, 32'h0004_0000);
        end
    endtask

    task automatic add_queries(int unsigned count);
        t_item it;
        for (int i = 0; i < count; i++) begin
            it = make_item(CMD_QUERY, $urandom_range(0, 32'h0110_0000));
            if ($urandom_range(0, 3) == 0) it.energy = $urandom;
            it.step = rand_small();
            if ($urandom_range(0, 4) == 0) it.fe = 16'($urandom_range(0, 512));
            push(it);
        end
    endtask

    task automatic random_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++) begin
            add_table($urandom_range(2, 12), $urandom_range(0, 7) != 0);
            add_queries($urandom_range(10, 30));
            if ($urandom_range(0, 5) == 0) push(make_item(CMD_RESERVED, $urandom));
        end
    endtask

    task automatic it_drive(t_item it);
        i_valid <= 1'b1;
        i_command <= it.command;
        i_energy <= it.energy;
        i_electronic_stopping <= it.se;
        i_nuclear_stopping <= it.sn;
        i_electron_density_factor <= it.fe;
        i_atom_density_factor <= it.fa;
        i_step_length <= it.step;
        expected_losses.insert(expected_losses.size(), predict_loss(it));
    endtask

    initial begin
        t_item it;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push(make_item(CMD_QUERY, 32'hffff_ffff));
        push(make_item(CMD_APPEND, 32'h0001_0000));
        push(make_item(CMD_QUERY, 32'h0001_0000));
        it = make_item(CMD_APPEND, 32'h0003_0000);
        it.se = 32'hffff_ffff;
        it.sn = 32'h0;
        push(it);
        for (int i = 0; i < 6; i++) begin
            it = make_item(CMD_QUERY, 32'h0000_8000 + i * 32'h0000_8000);
            it.fe = i[0] ? 16'hffff : 16'h0;
            it.fa = i[1] ? 16'hffff : 16'h0100;
            it.step = i[2] ? 32'hffff_ffff : 32'h0000_0001;
            push(it);
        end
        push(make_item(CMD_QUERY, 32'h0003_0000));
        push(make_item(CMD_QUERY, 32'h0));
        push(make_item(CMD_RESERVED, 32'hffff_ffff));
        push(make_item(CMD_APPEND, 32'h0000_0001));
        push(make_item(CMD_QUERY, 32'h0002_0000));
        push(make_item(CMD_QUERY, 32'h0000_0000));
        push(make_item(CMD_CLEAR, 32'h0));
        push(make_item(CMD_QUERY, 32'h0));
        drain();

        random_phase(0, 0, 12);
        drain();

        add_table(DEPTH, 1'b1);
        for (int i = 0; i < 4; i++) push(make_item(CMD_APPEND, $urandom));
        add_queries(40);
        hold_go = 1'b1;
        drain();

        random_phase(69, 0, 12);
        drain();
        random_phase(0, 69, 12);
        drain();
        random_phase(24, 24, 12);
        drain();
        repeat (20) @(posedge i_clk);

        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it_drive(pending_items.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 600;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_loss exp_r;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_losses.size() == 0) begin
                $error("unexpected result: new_energy %h", o_new_energy);
                errors++;
            end else begin
                exp_r = expected_losses.pop_front();
                if (o_new_energy !== exp_r.new_energy) begin
                    $error("new_energy expected %h actual %h", exp_r.new_energy, o_new_energy);
                    errors++;
                end
                if (o_row_count !== exp_r.row_count) begin
                    $error("row_count expected %0d actual %0d", exp_r.row_count, o_row_count);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    errors++;
                end
            end
        end
    end
endmodule

// ===== sim.f =====
src/spte_pkg.sv
src/spte_ctrl.sv
src/spte_dp.sv
src/stopping_power_table_energy_loss_top.sv
test/tb_top.sv
